// File: design/ttx_pkg.sv
// Shared types and constants for the teletext attribute cell decoder.
package ttx_pkg;

    // Draw kind of one cell.
    typedef enum logic [1:0] {
        KIND_FILL   = 2'd0,
        KIND_ALPHA  = 2'd1,
        KIND_MOSAIC = 2'd2,
        KIND_NONE   = 2'd3
    } cell_kind_t;

    // Cursor display modes.
    localparam logic [1:0] CUR_STEADY = 2'd0;
    localparam logic [1:0] CUR_HIDDEN = 2'd1;

    // Configuration register indexes.
    localparam logic [1:0] REG_CURSOR_LOCATION = 2'd0;
    localparam logic [1:0] REG_CURSOR_MODE     = 2'd1;
    localparam logic [1:0] REG_CURSOR_FIRST    = 2'd2;
    localparam logic [1:0] REG_CURSOR_LAST     = 2'd3;

    // Control codes, low five bits of a character below 0x20.
    localparam logic [4:0] CTL_ALPHA_LO   = 5'h00;
    localparam logic [4:0] CTL_ALPHA_HI   = 5'h07;
    localparam logic [4:0] CTL_FLASH_ON   = 5'h08;
    localparam logic [4:0] CTL_FLASH_OFF  = 5'h09;
    localparam logic [4:0] CTL_NORMAL_H   = 5'h0C;
    localparam logic [4:0] CTL_DOUBLE_H   = 5'h0D;
    localparam logic [4:0] CTL_GFX_LO     = 5'h10;
    localparam logic [4:0] CTL_GFX_HI     = 5'h17;
    localparam logic [4:0] CTL_CONCEAL    = 5'h18;
    localparam logic [4:0] CTL_CONTIGUOUS = 5'h19;
    localparam logic [4:0] CTL_SEPARATED  = 5'h1A;
    localparam logic [4:0] CTL_BLACK_BG   = 5'h1C;
    localparam logic [4:0] CTL_NEW_BG     = 5'h1D;
    localparam logic [4:0] CTL_HOLD_ON    = 5'h1E;
    localparam logic [4:0] CTL_HOLD_OFF   = 5'h1F;

    // Font layout: alpha glyphs first, then contiguous, then separated mosaics.
    localparam logic [7:0] GLYPH_ALPHA_OFFSET = 8'h20;
    localparam logic [7:0] GLYPH_MOSAIC_BASE  = 8'd96;
    localparam logic [7:0] GLYPH_SEP_OFFSET   = 8'd64;

    // Attribute reset colors.
    localparam logic [2:0] FORE_RESET = 3'd7;
    localparam logic [2:0] BACK_RESET = 3'd0;

    // Serial attribute mode flags.
    typedef struct packed {
        logic gfx;
        logic flash;
        logic conceal;
        logic sep;
        logic hold;
        logic dbl;
        logic have;
    } mode_flags_t;

    // Decoded cell as it travels from the front to the back.
    typedef struct packed {
        cell_kind_t  kind;
        logic [7:0]  glyph;
        logic [2:0]  fg;
        logic [2:0]  bg;
        logic        top;
        logic        lower;
        logic [10:0] addr;
        logic        blink;
    } ttx_item_t;

    // Cursor configuration handed to the back.
    typedef struct packed {
        logic [10:0] location;
        logic [1:0]  mode;
        logic [4:0]  first_line;
        logic [4:0]  last_line;
    } cursor_cfg_t;

endpackage

// File: design/ttx_front.sv
// Front: accepts cells, tracks serial attributes and column flags, decodes draw kind.
module ttx_front #(
    parameter int ROW_CELLS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        raw_char,
    input  logic [10:0]       cell_address,
    input  logic [5:0]        column,
    input  logic              frame_start,
    input  logic              row_start,
    input  logic              next_row_shown,
    input  logic              flash_show,
    input  logic              blink_phase_on,
    input  logic              q_full,
    output logic              q_push,
    output ttx_pkg::ttx_item_t q_item
);
    import ttx_pkg::*;

    localparam int IDX_W = $clog2(ROW_CELLS);

    logic [2:0]           fore_reg, fore_next;
    logic [2:0]           back_reg, back_next;
    logic [5:0]           held_reg, held_next;
    mode_flags_t          flags_reg, flags_next;
    logic [ROW_CELLS-1:0] now_reg, now_next;
    logic [ROW_CELLS-1:0] lower_reg, lower_next;

    logic [2:0]           fore_cur, back_cur;
    logic [5:0]           held_cur;
    mode_flags_t          flags_cur;
    logic [IDX_W+5:0]     col_ext;
    logic [IDX_W-1:0]     col_idx;
    logic                 col_ok;
    logic                 render;
    logic [6:0]           c;
    logic [5:0]           mosaic;
    logic [7:0]           sep_add;
    logic                 fire;

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;
    assign q_push   = fire;

    assign col_ext = {{IDX_W{1'b0}}, column};
    assign col_idx = col_ext[IDX_W-1:0];
    assign col_ok  = (32'(column) < ROW_CELLS);
    assign c       = raw_char[6:0];
    assign mosaic  = {c[6], c[4:0]};

    // A row start brings the attributes back to their reset values first.
    always_comb
    begin
        if (row_start)
        begin
            fore_cur  = FORE_RESET;
            back_cur  = BACK_RESET;
            held_cur  = '0;
            flags_cur = '0;
        end
        else
        begin
            fore_cur  = fore_reg;
            back_cur  = back_reg;
            held_cur  = held_reg;
            flags_cur = flags_reg;
        end
    end

    // Column flags: frame start clears both, row start moves next to current.
    always_comb
    begin
        if (frame_start)
        begin
            now_next   = '0;
            lower_next = '0;
        end
        else if (row_start)
        begin
            now_next   = lower_reg;
            lower_next = '0;
        end
        else
        begin
            now_next   = now_reg;
            lower_next = lower_reg;
        end
        render = !(col_ok && now_next[col_idx]);
        if (render && flags_cur.dbl && next_row_shown && col_ok)
        begin
            lower_next[col_idx] = 1'b1;
        end
    end

    assign sep_add = flags_cur.sep ? GLYPH_SEP_OFFSET : 8'd0;

    // Cell decode and attribute update; attribute changes apply after the cell.
    always_comb
    begin
        fore_next  = fore_cur;
        back_next  = back_cur;
        held_next  = held_cur;
        flags_next = flags_cur;

        q_item.kind  = KIND_FILL;
        q_item.glyph = '0;
        q_item.fg    = raw_char[7] ? back_cur : fore_cur;
        q_item.bg    = raw_char[7] ? fore_cur : back_cur;
        q_item.top   = flags_cur.dbl;
        q_item.lower = render && flags_cur.dbl && next_row_shown;
        q_item.addr  = cell_address;
        q_item.blink = blink_phase_on;

        if (c[6:5] == 2'b00)
        begin
            // Control code: show the held mosaic where hold applies.
            if (flags_cur.gfx && (flags_cur.hold || c[4:0] == CTL_HOLD_ON) && flags_cur.have)
            begin
                q_item.kind  = KIND_MOSAIC;
                q_item.glyph = GLYPH_MOSAIC_BASE + {2'b00, held_cur} + sep_add;
            end
            case (c[4:0]) inside
                [CTL_ALPHA_LO:CTL_ALPHA_HI]:
                begin
                    fore_next          = c[2:0];
                    flags_next.gfx     = 1'b0;
                    flags_next.conceal = 1'b0;
                end
                [CTL_GFX_LO:CTL_GFX_HI]:
                begin
                    fore_next          = c[2:0];
                    flags_next.gfx     = 1'b1;
                    flags_next.conceal = 1'b0;
                end
                CTL_FLASH_ON:   flags_next.flash   = 1'b1;
                CTL_FLASH_OFF:  flags_next.flash   = 1'b0;
                CTL_NORMAL_H:   flags_next.dbl     = 1'b0;
                CTL_DOUBLE_H:   flags_next.dbl     = 1'b1;
                CTL_CONCEAL:    flags_next.conceal = 1'b1;
                CTL_CONTIGUOUS: flags_next.sep     = 1'b0;
                CTL_SEPARATED:  flags_next.sep     = 1'b1;
                CTL_BLACK_BG:   back_next          = BACK_RESET;
                CTL_NEW_BG:     back_next          = fore_cur;
                CTL_HOLD_ON:    flags_next.hold    = 1'b1;
                CTL_HOLD_OFF:
                begin
                    flags_next.hold = 1'b0;
                    flags_next.have = 1'b0;
                end
                default: ;
            endcase
        end
        else if (flags_cur.conceal || (flags_cur.flash && !flash_show))
        begin
            q_item.kind = KIND_FILL;
        end
        else if (flags_cur.gfx && c[5])
        begin
            q_item.kind     = KIND_MOSAIC;
            q_item.glyph    = GLYPH_MOSAIC_BASE + {2'b00, mosaic} + sep_add;
            held_next       = mosaic;
            flags_next.have = 1'b1;
        end
        else
        begin
            q_item.kind  = KIND_ALPHA;
            q_item.glyph = {1'b0, c} - GLYPH_ALPHA_OFFSET;
        end

        // A cell covered by a lower half above is not drawn.
        if (!render)
        begin
            q_item.kind  = KIND_NONE;
            q_item.glyph = '0;
            q_item.fg    = '0;
            q_item.bg    = '0;
            q_item.top   = 1'b0;
        end
    end

    // Attribute and column flag state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fore_reg  <= FORE_RESET;
            back_reg  <= BACK_RESET;
            held_reg  <= '0;
            flags_reg <= '0;
            now_reg   <= '0;
            lower_reg <= '0;
        end
        else if (fire)
        begin
            fore_reg  <= fore_next;
            back_reg  <= back_next;
            held_reg  <= held_next;
            flags_reg <= flags_next;
            now_reg   <= now_next;
            lower_reg <= lower_next;
        end
    end

endmodule

// File: design/ttx_queue.sv
// Short queue of decoded cells between the front and the back.
module ttx_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ttx_pkg::ttx_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output ttx_pkg::ttx_item_t head_item
);
    import ttx_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ttx_item_t        store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = store_reg[rd_ptr_reg];

    // Pointer wrap and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: design/ttx_back.sv
// Back: resolves the cursor for each decoded cell and holds the output register.
module ttx_back #(
    parameter int CELL_LINES = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ttx_pkg::cursor_cfg_t cfg,
    input  logic                 q_valid,
    input  ttx_pkg::ttx_item_t   q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           cell_kind,
    output logic [7:0]           glyph_code,
    output logic [2:0]           fg_colour,
    output logic [2:0]           bg_colour,
    output logic                 top_half,
    output logic                 draw_lower,
    output logic                 cursor_on,
    output logic [3:0]           cursor_top,
    output logic [3:0]           cursor_bottom
);
    import ttx_pkg::*;

    localparam logic [4:0] MAX_LINE = 5'(CELL_LINES - 1);

    ttx_item_t  item_reg;
    logic       valid_reg;
    logic       cur_on_reg, cur_on_next;
    logic [3:0] ctop_reg, ctop_next;
    logic [3:0] cbot_reg, cbot_next;
    logic       cur_vis;
    logic [4:0] top_clamp, bot_clamp;

    assign q_pop = q_valid && (!valid_reg || out_ready);

    // Cursor visibility, match and line clamping.
    always_comb
    begin
        case (cfg.mode)
            CUR_HIDDEN: cur_vis = 1'b0;
            CUR_STEADY: cur_vis = 1'b1;
            default:    cur_vis = q_item.blink;
        endcase
        cur_on_next = cur_vis && (q_item.addr == cfg.location);
        top_clamp   = (cfg.first_line > MAX_LINE) ? MAX_LINE : cfg.first_line;
        bot_clamp   = (cfg.last_line > MAX_LINE) ? MAX_LINE : cfg.last_line;
        if (bot_clamp < top_clamp)
        begin
            bot_clamp = top_clamp;
        end
        ctop_next = cur_on_next ? top_clamp[3:0] : 4'd0;
        cbot_next = cur_on_next ? bot_clamp[3:0] : 4'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg   <= q_item;
            cur_on_reg <= cur_on_next;
            ctop_reg   <= ctop_next;
            cbot_reg   <= cbot_next;
        end
    end

    assign out_valid     = valid_reg;
    assign cell_kind     = item_reg.kind;
    assign glyph_code    = item_reg.glyph;
    assign fg_colour     = item_reg.fg;
    assign bg_colour     = item_reg.bg;
    assign top_half      = item_reg.top;
    assign draw_lower    = item_reg.lower;
    assign cursor_on     = cur_on_reg;
    assign cursor_top    = ctop_reg;
    assign cursor_bottom = cbot_reg;

endmodule

// File: design/teletext_attribute_cell_decoder.sv
// An accepted cell is written into the queue entry, then into the back's output register,
// and from there it drives the outputs. Throughput: one cell per cycle, sustained while
// out_ready stays high; the attribute update in the front and the output register in the
// back each take a cell every cycle then. A two-entry queue lets front and back stall
// independently. Reset (rst_n low, asynchronous) clears attributes, column flags and queue,
// and sets the cursor registers to location 0, hidden, lines 8 to 9.
module teletext_attribute_cell_decoder #(
    parameter int ROW_CELLS  = 64,
    parameter int CELL_LINES = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  raw_char,
    input  logic [10:0] cell_address,
    input  logic [5:0]  column,
    input  logic        frame_start,
    input  logic        row_start,
    input  logic        next_row_shown,
    input  logic        flash_show,
    input  logic        blink_phase_on,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  cell_kind,
    output logic [7:0]  glyph_code,
    output logic [2:0]  fg_colour,
    output logic [2:0]  bg_colour,
    output logic        top_half,
    output logic        draw_lower,
    output logic        cursor_on,
    output logic [3:0]  cursor_top,
    output logic [3:0]  cursor_bottom
);
    import ttx_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    cursor_cfg_t cfg_reg;
    logic        cfg_write;
    logic [1:0]  reg_index;
    logic        q_full, q_push, q_pop, q_valid;
    ttx_item_t   push_item, head_item;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Cursor configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.location   <= 11'd0;
            cfg_reg.mode       <= CUR_HIDDEN;
            cfg_reg.first_line <= 5'd8;
            cfg_reg.last_line  <= 5'd9;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_CURSOR_LOCATION: cfg_reg.location   <= pwdata[10:0];
                REG_CURSOR_MODE:     cfg_reg.mode       <= pwdata[1:0];
                REG_CURSOR_FIRST:    cfg_reg.first_line <= pwdata[4:0];
                REG_CURSOR_LAST:     cfg_reg.last_line  <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_index)
            REG_CURSOR_LOCATION: prdata = {21'd0, cfg_reg.location};
            REG_CURSOR_MODE:     prdata = {30'd0, cfg_reg.mode};
            REG_CURSOR_FIRST:    prdata = {27'd0, cfg_reg.first_line};
            REG_CURSOR_LAST:     prdata = {27'd0, cfg_reg.last_line};
            default:             prdata = '0;
        endcase
    end

    ttx_front #(
        .ROW_CELLS(ROW_CELLS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .raw_char       (raw_char),
        .cell_address   (cell_address),
        .column         (column),
        .frame_start    (frame_start),
        .row_start      (row_start),
        .next_row_shown (next_row_shown),
        .flash_show     (flash_show),
        .blink_phase_on (blink_phase_on),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (push_item)
    );

    ttx_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_item (head_item)
    );

    ttx_back #(
        .CELL_LINES(CELL_LINES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cell_kind     (cell_kind),
        .glyph_code    (glyph_code),
        .fg_colour     (fg_colour),
        .bg_colour     (bg_colour),
        .top_half      (top_half),
        .draw_lower    (draw_lower),
        .cursor_on     (cursor_on),
        .cursor_top    (cursor_top),
        .cursor_bottom (cursor_bottom)
    );

endmodule

// File: tb/teletext_attribute_cell_decoder_test.sv
// Self-checking testbench for the teletext attribute cell decoder.
`timescale 1ns / 100ps

module teletext_attribute_cell_decoder_test;
    import ttx_pkg::*;

    // Cursor modes that have no name in the package.
    localparam logic [1:0] CUR_SLOW_BLINK = 2'd2;
    localparam logic [1:0] CUR_FAST_BLINK = 2'd3;

    localparam int LAST_LINE   = 9;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 208;

    // One screen cell as presented to the decoder.
    typedef struct packed {
        logic [7:0]  raw;
        logic [10:0] addr;
        logic [5:0]  col;
        logic        frame;
        logic        row;
        logic        next_shown;
        logic        flash_vis;
        logic        blink;
    } cell_in_t;

    // One decoded cell as the decoder returns it.
    typedef struct packed {
        cell_kind_t  kind;
        logic [7:0]  glyph;
        logic [2:0]  fg;
        logic [2:0]  bg;
        logic        top;
        logic        lower;
        logic        cur_on;
        logic [3:0]  ctop;
        logic [3:0]  cbot;
    } cell_out_t;

    // A directed cell, with a hand-written result where one is given.
    typedef struct packed {
        cell_in_t  stim;
        logic      typed;
        cell_out_t known;
    } directed_row_t;

    // Directed cells: extremes, attribute changes, held mosaics, double height and covered cells.
    localparam directed_row_t DIRECTED [25] = '{
        '{'{8'h41, 11'h000, 6'd0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b1,
          '{KIND_ALPHA, 8'h21, 3'd7, 3'd0, 1'b0, 1'b0, 1'b0, 4'd0, 4'd0}},
        '{'{8'hFF, 11'h7FF, 6'd1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b1,
          '{KIND_ALPHA, 8'h5F, 3'd0, 3'd7, 1'b0, 1'b0, 1'b0, 4'd0, 4'd0}},
        '{'{8'h91, 11'h002, 6'd2, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b1,
          '{KIND_FILL, 8'h00, 3'd0, 3'd7, 1'b0, 1'b0, 1'b0, 4'd0, 4'd0}},
        '{'{8'h7F, 11'h003, 6'd3, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h1A, 11'h004, 6'd4, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h20, 11'h005, 6'd5, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h40, 11'h006, 6'd6, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h1E, 11'h007, 6'd7, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h02, 11'h008, 6'd8, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h1D, 11'h009, 6'd9, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h08, 11'h00A, 6'd10, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h42, 11'h00B, 6'd11, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h42, 11'h00C, 6'd12, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h18, 11'h00D, 6'd13, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h43, 11'h00E, 6'd14, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h0D, 11'h00F, 6'd15, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h04, 11'h010, 6'd16, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h44, 11'h011, 6'd17, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h0E, 11'h012, 6'd18, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h1F, 11'h013, 6'd19, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h45, 11'h040, 6'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h45, 11'h050, 6'd16, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b1,
          '{KIND_NONE, 8'h00, 3'd0, 3'd0, 1'b0, 1'b0, 1'b0, 4'd0, 4'd0}},
        '{'{8'h0D, 11'h051, 6'd17, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b1,
          '{KIND_NONE, 8'h00, 3'd0, 3'd0, 1'b0, 1'b0, 1'b0, 4'd0, 4'd0}},
        '{'{8'h46, 11'h052, 6'd18, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h47, 11'h080, 6'd16, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0}
    };

    // Cursor settings per phase; phase 0 keeps the reset values.
    localparam logic [1:0] PHASE_MODE [N_PHASES] =
        '{CUR_HIDDEN, CUR_STEADY, CUR_SLOW_BLINK, CUR_FAST_BLINK, CUR_STEADY, CUR_HIDDEN};
    localparam logic [4:0] PHASE_FIRST [N_PHASES] = '{5'd8, 5'd0, 5'd31, 5'd9, 5'd31, 5'd5};
    localparam logic [4:0] PHASE_LAST [N_PHASES]  = '{5'd9, 5'd0, 5'd31, 5'd3, 5'd0, 5'd31};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  raw_char = '0;
    logic [10:0] cell_address = '0;
    logic [5:0]  column = '0;
    logic        frame_start = 1'b0;
    logic        row_start = 1'b0;
    logic        next_row_shown = 1'b0;
    logic        flash_show = 1'b0;
    logic        blink_phase_on = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  cell_kind;
    logic [7:0]  glyph_code;
    logic [2:0]  fg_colour;
    logic [2:0]  bg_colour;
    logic        top_half;
    logic        draw_lower;
    logic        cursor_on;
    logic [3:0]  cursor_top;
    logic [3:0]  cursor_bottom;

    // Shadow of the cursor registers.
    logic [10:0] cur_location = '0;
    logic [1:0]  cur_mode = CUR_HIDDEN;
    logic [4:0]  cur_first = 5'd8;
    logic [4:0]  cur_last = 5'd9;

    // Serial attributes and per-column lower-half flags of the predictor.
    logic [2:0]  attr_fore = FORE_RESET;
    logic [2:0]  attr_back = BACK_RESET;
    logic [5:0]  kept_mosaic = '0;
    mode_flags_t attr_flags = '0;
    logic [63:0] covered_now = '0;
    logic [63:0] covered_next = '0;

    // Random row generator position.
    int gen_col = 0;
    int gen_row_len = 1;
    int gen_rows_left = 0;
    logic [10:0] gen_addr = '0;

    cell_out_t decoded_due [$];
    int        failures = 0;
    bit        no_idle = 1'b0;

    teletext_attribute_cell_decoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .raw_char       (raw_char),
        .cell_address   (cell_address),
        .column         (column),
        .frame_start    (frame_start),
        .row_start      (row_start),
        .next_row_shown (next_row_shown),
        .flash_show     (flash_show),
        .blink_phase_on (blink_phase_on),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cell_kind      (cell_kind),
        .glyph_code     (glyph_code),
        .fg_colour      (fg_colour),
        .bg_colour      (bg_colour),
        .top_half       (top_half),
        .draw_lower     (draw_lower),
        .cursor_on      (cursor_on),
        .cursor_top     (cursor_top),
        .cursor_bottom  (cursor_bottom)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decode one cell and advance the attribute and column state.
    function automatic cell_out_t decode_cell(input cell_in_t c);
        cell_out_t r;
        logic [6:0] code;
        logic [5:0] mosaic;
        logic [4:0] first_c;
        logic [4:0] last_c;
        logic       covered;
        logic       visible;
        r = '0;
        code = c.raw[6:0];
        if (c.frame)
        begin
            covered_now = '0;
            covered_next = '0;
        end
        if (c.row)
        begin
            covered_now = covered_next;
            covered_next = '0;
            attr_fore = FORE_RESET;
            attr_back = BACK_RESET;
            kept_mosaic = '0;
            attr_flags = '0;
        end
        covered = covered_now[c.col];
        r.lower = !covered && attr_flags.dbl && c.next_shown;
        r.top = attr_flags.dbl;
        r.fg = c.raw[7] ? attr_back : attr_fore;
        r.bg = c.raw[7] ? attr_fore : attr_back;

        if (code < 7'h20)
        begin
            // Control cell: held mosaic or fill, then the attribute change.
            if (attr_flags.gfx && (attr_flags.hold || code[4:0] == CTL_HOLD_ON) && attr_flags.have)
            begin
                r.kind = KIND_MOSAIC;
                r.glyph = GLYPH_MOSAIC_BASE + {2'b00, kept_mosaic} +
                          (attr_flags.sep ? GLYPH_SEP_OFFSET : 8'd0);
            end
            else
                r.kind = KIND_FILL;
            if (code[4:0] <= CTL_ALPHA_HI)
            begin
                attr_fore = code[2:0];
                attr_flags.gfx = 1'b0;
                attr_flags.conceal = 1'b0;
            end
            else if (code[4:0] >= CTL_GFX_LO && code[4:0] <= CTL_GFX_HI)
            begin
                attr_fore = code[2:0];
                attr_flags.gfx = 1'b1;
                attr_flags.conceal = 1'b0;
            end
            else
            begin
                case (code[4:0])
                    CTL_FLASH_ON:   attr_flags.flash = 1'b1;
                    CTL_FLASH_OFF:  attr_flags.flash = 1'b0;
                    CTL_NORMAL_H:   attr_flags.dbl = 1'b0;
                    CTL_DOUBLE_H:   attr_flags.dbl = 1'b1;
                    CTL_CONCEAL:    attr_flags.conceal = 1'b1;
                    CTL_CONTIGUOUS: attr_flags.sep = 1'b0;
                    CTL_SEPARATED:  attr_flags.sep = 1'b1;
                    CTL_BLACK_BG:   attr_back = BACK_RESET;
                    CTL_NEW_BG:     attr_back = attr_fore;
                    CTL_HOLD_ON:    attr_flags.hold = 1'b1;
                    CTL_HOLD_OFF:
                    begin
                        attr_flags.hold = 1'b0;
                        attr_flags.have = 1'b0;
                    end
                    default: ;
                endcase
            end
        end
        else if (attr_flags.conceal || (attr_flags.flash && !c.flash_vis))
            r.kind = KIND_FILL;
        else if (attr_flags.gfx && (code < 7'h40 || code >= 7'h60))
        begin
            // Mosaic character: bit 6 of the code becomes bit 5 of the pattern.
            mosaic = {code[6], code[4:0]};
            r.kind = KIND_MOSAIC;
            r.glyph = GLYPH_MOSAIC_BASE + {2'b00, mosaic} +
                      (attr_flags.sep ? GLYPH_SEP_OFFSET : 8'd0);
            kept_mosaic = mosaic;
            attr_flags.have = 1'b1;
        end
        else
        begin
            r.kind = KIND_ALPHA;
            r.glyph = {1'b0, code} - GLYPH_ALPHA_OFFSET;
        end

        if (r.lower)
            covered_next[c.col] = 1'b1;
        if (covered)
        begin
            r.kind = KIND_NONE;
            r.glyph = '0;
            r.fg = '0;
            r.bg = '0;
            r.top = 1'b0;
        end

        // Cursor match and clamped scan lines.
        case (cur_mode)
            CUR_HIDDEN: visible = 1'b0;
            CUR_STEADY: visible = 1'b1;
            default:    visible = c.blink;
        endcase
        r.cur_on = visible && c.addr == cur_location;
        if (r.cur_on)
        begin
            first_c = (cur_first > 5'(LAST_LINE)) ? 5'(LAST_LINE) : cur_first;
            last_c = (cur_last > 5'(LAST_LINE)) ? 5'(LAST_LINE) : cur_last;
            if (last_c < first_c)
                last_c = first_c;
            r.ctop = first_c[3:0];
            r.cbot = last_c[3:0];
        end
        return r;
    endfunction

    // Next random cell: mostly well-formed rows and frames, some noise.
    function automatic cell_in_t next_random_cell();
        cell_in_t c;
        int pick;
        c = '0;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            case ($urandom_range(3))
                0: c.raw[4:0] = CTL_DOUBLE_H;
                1: c.raw[4:0] = CTL_HOLD_ON;
                2: c.raw[4:0] = CTL_GFX_LO | 5'($urandom_range(7));
                default: c.raw[4:0] = CTL_SEPARATED;
            endcase
        end
        else if (pick < 35)
            c.raw[4:0] = 5'($urandom_range(31));
        else
            c.raw[6:0] = 7'($urandom_range(32, 127));
        c.raw[7] = 1'($urandom_range(1));

        if ($urandom_range(99) < 8)
        begin
            c.col = 6'($urandom);
            c.addr = 11'($urandom);
            c.frame = ($urandom_range(9) == 0);
            c.row = ($urandom_range(3) == 0);
        end
        else
        begin
            c.row = (gen_col == 0);
            if (c.row)
            begin
                if (gen_rows_left == 0)
                begin
                    c.frame = 1'b1;
                    gen_rows_left = $urandom_range(1, 6);
                    gen_addr = 11'($urandom);
                end
                gen_rows_left--;
                gen_row_len = ($urandom_range(9) == 0) ? 64 : $urandom_range(4, 40);
            end
            c.col = 6'(gen_col);
            c.addr = gen_addr;
            gen_addr++;
            gen_col = (gen_col + 1 == gen_row_len) ? 0 : gen_col + 1;
        end

        if ($urandom_range(9) == 0)
            c.addr = cur_location;
        c.next_shown = ($urandom_range(99) < 85);
        c.flash_vis = 1'($urandom_range(1));
        c.blink = 1'($urandom_range(1));
        return c;
    endfunction

    // Offer one cell, wait for it to be taken, and queue its decoded result.
    task automatic send_cell(input cell_in_t c, input logic typed, input cell_out_t known);
        cell_out_t predicted;
        while (!no_idle && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_char <= c.raw;
        cell_address <= c.addr;
        column <= c.col;
        frame_start <= c.frame;
        row_start <= c.row;
        next_row_shown <= c.next_shown;
        flash_show <= c.flash_vis;
        blink_phase_on <= c.blink;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = decode_cell(c);
        decoded_due.push_back(typed ? known : predicted);
    endtask

    // Hold off the sender until every queued result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (decoded_due.size() != 0);
    endtask

    // One register write: setup cycle, then access cycle.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_CURSOR_LOCATION: cur_location = value[10:0];
            REG_CURSOR_MODE:     cur_mode = value[1:0];
            REG_CURSOR_FIRST:    cur_first = value[4:0];
            REG_CURSOR_LAST:     cur_last = value[4:0];
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            failures++;
        end
    endtask

    // The receiver stalls at random, except during the steady stretch.
    always @(posedge clk)
        out_ready <= no_idle || ($urandom_range(99) >= 14);

    // Compare every taken result with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        cell_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_due.size() == 0)
            begin
                $display("%0t ns: result with nothing expected, kind %0d glyph %0d",
                         $time, cell_kind, glyph_code);
                failures++;
            end
            else
            begin
                want = decoded_due.pop_front();
                check_field("cell_kind", 8'(want.kind), 8'(cell_kind));
                check_field("glyph_code", want.glyph, glyph_code);
                check_field("fg_colour", 8'(want.fg), 8'(fg_colour));
                check_field("bg_colour", 8'(want.bg), 8'(bg_colour));
                check_field("top_half", 8'(want.top), 8'(top_half));
                check_field("draw_lower", 8'(want.lower), 8'(draw_lower));
                check_field("cursor_on", 8'(want.cur_on), 8'(cursor_on));
                check_field("cursor_top", 8'(want.ctop), 8'(cursor_top));
                check_field("cursor_bottom", 8'(want.cbot), 8'(cursor_bottom));
            end
        end
    end

    // Main sequence: reset, directed cells, then random phases under several cursor settings.
    initial
    begin
        logic [10:0] loc;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_cell(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].known);

        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            wait_drained();
            if (phase > 0)
            begin
                loc = (phase == 1) ? 11'h000 : (phase == 2) ? 11'h7FF : 11'($urandom);
                write_reg(REG_CURSOR_LOCATION, 32'(loc));
                write_reg(REG_CURSOR_MODE, 32'(PHASE_MODE[phase]));
                write_reg(REG_CURSOR_FIRST, 32'(PHASE_FIRST[phase]));
                write_reg(REG_CURSOR_LAST, 32'(PHASE_LAST[phase]));
                psel <= 1'b0;
                penable <= 1'b0;
            end
            // One phase runs with neither side idling at random, apart from the drain halfway through.
            no_idle = (phase == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    wait_drained();
                send_cell(next_random_cell(), 1'b0, '0);
            end
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (10) @(posedge clk);
        if (failures == 0 && decoded_due.size() == 0)
            $display("teletext_attribute_cell_decoder verification clean");
        else
            $display("teletext_attribute_cell_decoder verification failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("teletext_attribute_cell_decoder verification failed");
        $finish;
    end

endmodule
